>>> rtl/core/ac3_eac3_header_decoder_defines.svh
// Assertion macros shared by the header decoder RTL.
// Depends on nothing; the asserting modules name their clock clk_i and reset rst_ni.
`ifndef AC3_EAC3_HEADER_DECODER_DEFINES_SVH
`define AC3_EAC3_HEADER_DECODER_DEFINES_SVH
`ifndef SYNTHESIS
// Property checked on every clock edge outside reset.
`define AC3EAC_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error("check failed");
// Condition that must never be true outside reset.
`define AC3EAC_NEVER(lbl, cond) \
  `AC3EAC_ASSERT(lbl, !(cond))
`else
`define AC3EAC_ASSERT(lbl, prop)
`define AC3EAC_NEVER(lbl, cond)
`endif
`endif

>>> rtl/core/ac3eac_pkg.sv
// Types, constants and lookup tables for the AC-3 / E-AC-3 header decoder.
// Used by every module of the block; depends on nothing.
package ac3eac_pkg;

  localparam int HdrW = 56;
  localparam int QDepth = 2;
  localparam int QPtrW = 1;
  localparam int QCntW = 2;
  localparam int DivW = 32;
  localparam int DivStepsPerCycle = 4;
  localparam int DivCntW = 3;
  localparam logic [15:0] SyncWord = 16'h0B77;
  localparam logic [4:0] BsidEac3Above = 5'd10;
  localparam logic [19:0] TicksBits = 20'd720000;  // 8 bits per byte times 90 kHz

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_BAD_SYNC  = 3'd1,
    ST_RSV_TYPE  = 3'd2,
    ST_SHORT     = 3'd3,
    ST_RSV_RATE  = 3'd4,
    ST_BAD_CODE  = 3'd5
  } status_e;

  typedef enum logic [2:0] {
    B_IDLE,
    B_DIV1,
    B_MUL,
    B_DIV2,
    B_OUT
  } back_state_e;

  // One classified header, as it travels from front to back.
  typedef struct packed {
    status_e       status;
    logic          enhanced;
    logic [12:0]   frame_bytes;
    logic [15:0]   sample_rate;
    logic [2:0]    channels;
    logic [DivW-1:0] rate_num;
    logic [7:0]    rate_den;
  } hdr_item_t;

  function automatic logic [15:0] rate_hz(input logic [1:0] code);
    logic [15:0] r;
    begin
      case (code)
        2'd0: r = 16'd48000;
        2'd1: r = 16'd44100;
        2'd2: r = 16'd32000;
        default: r = 16'd0;
      endcase
      return r;
    end
  endfunction

  function automatic logic [2:0] mode_channels(input logic [2:0] acmod);
    logic [2:0] c;
    begin
      case (acmod)
        3'd0: c = 3'd2;
        3'd1: c = 3'd1;
        3'd2: c = 3'd2;
        3'd3: c = 3'd3;
        3'd4: c = 3'd3;
        3'd5: c = 3'd4;
        3'd6: c = 3'd4;
        default: c = 3'd5;
      endcase
      return c;
    end
  endfunction

  function automatic logic [9:0] kbps(input logic [4:0] idx);
    logic [9:0] k;
    begin
      case (idx)
        5'd0: k = 10'd32;   5'd1: k = 10'd40;   5'd2: k = 10'd48;
        5'd3: k = 10'd56;   5'd4: k = 10'd64;   5'd5: k = 10'd80;
        5'd6: k = 10'd96;   5'd7: k = 10'd112;  5'd8: k = 10'd128;
        5'd9: k = 10'd160;  5'd10: k = 10'd192; 5'd11: k = 10'd224;
        5'd12: k = 10'd256; 5'd13: k = 10'd320; 5'd14: k = 10'd384;
        5'd15: k = 10'd448; 5'd16: k = 10'd512; 5'd17: k = 10'd576;
        5'd18: k = 10'd640;
        default: k = 10'd0;
      endcase
      return k;
    end
  endfunction

  // Frame words at 44.1 kHz for the even size code of each pair.
  function automatic logic [10:0] words_44k(input logic [4:0] idx);
    logic [10:0] w;
    begin
      case (idx)
        5'd0: w = 11'd69;    5'd1: w = 11'd87;    5'd2: w = 11'd104;
        5'd3: w = 11'd121;   5'd4: w = 11'd139;   5'd5: w = 11'd174;
        5'd6: w = 11'd208;   5'd7: w = 11'd243;   5'd8: w = 11'd278;
        5'd9: w = 11'd348;   5'd10: w = 11'd417;  5'd11: w = 11'd487;
        5'd12: w = 11'd557;  5'd13: w = 11'd696;  5'd14: w = 11'd835;
        5'd15: w = 11'd975;  5'd16: w = 11'd1114; 5'd17: w = 11'd1253;
        5'd18: w = 11'd1393;
        default: w = 11'd0;
      endcase
      return w;
    end
  endfunction

endpackage

>>> rtl/core/ac3eac_front.sv
// Front end: checks the sync word and classifies one header into a request for the back end.
// Depends on ac3eac_pkg.
module ac3eac_front import ac3eac_pkg::*; (
  input  logic [HdrW-1:0] header_bits_i,
  output hdr_item_t       item_o
);

  logic [1:0]  ftype, code, code2, fscod;
  logic [10:0] frmsiz;
  logic [12:0] fbytes;
  logic [2:0]  eac_acmod, ac_acmod;
  logic [5:0]  fsc;
  logic [15:0] eac_rate;
  logic [7:0]  eac_den;
  logic [10:0] words;
  logic        ac_lfe;
  logic [28:0] eac_num;

  assign ftype     = header_bits_i[39:38];
  assign frmsiz    = header_bits_i[34:24];
  assign code      = header_bits_i[23:22];
  assign code2     = header_bits_i[21:20];
  assign eac_acmod = header_bits_i[19:17];
  assign fscod     = header_bits_i[23:22];
  assign fsc       = header_bits_i[21:16];
  assign ac_acmod  = header_bits_i[7:5];
  assign fbytes    = {1'b0, frmsiz + 11'd0, 1'b0} + 13'd2;

  // E-AC-3 rate and block count; the reduced-rate code halves the rate and fixes six blocks.
  always_comb begin
    if (code == 2'd3) begin
      eac_rate = rate_hz(code2) >> 1;
      eac_den  = 8'd192;
    end else begin
      eac_rate = rate_hz(code);
      case (code2)
        2'd0: eac_den = 8'd32;
        2'd1: eac_den = 8'd64;
        2'd2: eac_den = 8'd96;
        default: eac_den = 8'd192;
      endcase
    end
  end

  assign eac_num = 29'(fbytes) * 29'(eac_rate);

  // AC-3 frame words per size code and rate, and the LFE bit whose place follows acmod.
  always_comb begin
    case (fscod)
      2'd0: words = {kbps(fsc[5:1]), 1'b0};
      2'd1: words = words_44k(fsc[5:1]) + {10'd0, fsc[0]};
      default: words = 11'(kbps(fsc[5:1])) * 11'd3;
    endcase
    if (ac_acmod == 3'd2) begin
      ac_lfe = header_bits_i[2];
    end else begin
      case ({ac_acmod[2], ac_acmod[0] & (ac_acmod != 3'd1)})
        2'b00: ac_lfe = header_bits_i[4];
        2'b11: ac_lfe = header_bits_i[0];
        default: ac_lfe = header_bits_i[2];
      endcase
    end
  end

  // Status and fields; a failing header carries zero work so the back end yields zeros.
  always_comb begin
    item_o = '0;
    item_o.status = ST_OK;
    item_o.rate_den = 8'd1;
    if (header_bits_i[55:40] != SyncWord) begin
      item_o.status = ST_BAD_SYNC;
    end else begin
      item_o.enhanced = header_bits_i[15:11] > BsidEac3Above;
      if (item_o.enhanced) begin
        if (ftype == 2'd3) begin
          item_o.status = ST_RSV_TYPE;
        end else if (frmsiz < 11'd3) begin
          item_o.status = ST_SHORT;
        end else if (code == 2'd3 && code2 == 2'd3) begin
          item_o.status = ST_RSV_RATE;
        end else begin
          item_o.frame_bytes = fbytes;
          item_o.sample_rate = eac_rate;
          item_o.channels = mode_channels(eac_acmod) + {2'd0, header_bits_i[16]};
          item_o.rate_num = {3'd0, eac_num};
          item_o.rate_den = eac_den;
        end
      end else begin
        if (fscod == 2'd3) begin
          item_o.status = ST_RSV_RATE;
        end else if (fsc > 6'd37) begin
          item_o.status = ST_BAD_CODE;
        end else begin
          item_o.frame_bytes = {1'b0, words, 1'b0};
          item_o.sample_rate = rate_hz(fscod);
          item_o.channels = mode_channels(ac_acmod) + {2'd0, ac_lfe};
          item_o.rate_num = DivW'(kbps(fsc[5:1])) * DivW'(10'd1000);
          item_o.rate_den = 8'd1;
        end
      end
    end
  end

endmodule

>>> rtl/core/ac3eac_queue.sv
// Two-entry queue of classified requests between the front and back ends.
// Depends on ac3eac_pkg and the assertion macro header.
`include "ac3_eac3_header_decoder_defines.svh"
module ac3eac_queue import ac3eac_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  hdr_item_t item_i,
  output logic      full_o,
  input  logic      pop_i,
  output logic      empty_o,
  output hdr_item_t item_o
);

  hdr_item_t             mem_q [QDepth];
  logic [QPtrW-1:0]      wr_ptr_q, rd_ptr_q;
  logic [QCntW-1:0]      count_q;
  logic                  do_push, do_pop;

  assign full_o  = count_q == QCntW'(QDepth);
  assign empty_o = count_q == '0;
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign item_o  = mem_q[rd_ptr_q];

  // Storage is written only on an accepted request.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (do_pop) rd_ptr_q <= rd_ptr_q + 1'b1;
      case ({do_push, do_pop})
        2'b10: count_q <= count_q + 1'b1;
        2'b01: count_q <= count_q - 1'b1;
        default: count_q <= count_q;
      endcase
    end
  end

  `AC3EAC_NEVER(q_overfill, count_q > QCntW'(QDepth))
  `AC3EAC_ASSERT(q_push_grows, do_push && !do_pop |=> count_q == $past(count_q) + 1'b1)
  `AC3EAC_ASSERT(q_pop_shrinks, do_pop && !do_push |=> count_q == $past(count_q) - 1'b1)
  `AC3EAC_ASSERT(q_ptr_gap, empty_o || full_o || wr_ptr_q != rd_ptr_q)

endmodule

>>> rtl/core/ac3eac_div.sv
// Shared restoring divider, four quotient bits per cycle.
// Depends on ac3eac_pkg.
module ac3eac_div import ac3eac_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [DivW-1:0] dividend_i,
  input  logic [DivW-1:0] divisor_i,
  output logic            done_o,
  output logic [DivW-1:0] quot_o
);

  logic [DivW-1:0]    rem_q, quo_q, div_q;
  logic [DivCntW-1:0] cnt_q;
  logic               busy_q, done_q;
  logic [DivW:0]      r;
  logic [DivW-1:0]    q;

  // Four dependent shift-compare-subtract steps.
  always_comb begin
    r = {1'b0, rem_q};
    q = quo_q;
    for (int k = 0; k < DivStepsPerCycle; k++) begin
      r = {r[DivW-1:0], q[DivW-1]};
      q = {q[DivW-2:0], 1'b0};
      if (r >= {1'b0, div_q}) begin
        r = r - {1'b0, div_q};
        q[0] = 1'b1;
      end
    end
  end

  // Operand and partial result registers.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      div_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= r[DivW-1:0];
      quo_q <= q;
    end
  end

  // Step counter and completion flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == '1);
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == '1) busy_q <= 1'b0;
      end
    end
  end

  assign done_o = done_q;
  assign quot_o = quo_q;

endmodule

>>> rtl/core/ac3eac_back.sv
// Back end: derives bit rate and frame duration with the shared divider, holds the result.
// Depends on ac3eac_pkg and ac3eac_div.
module ac3eac_back import ac3eac_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        q_empty_i,
  input  hdr_item_t   item_i,
  output logic        q_pop_o,
  output logic        empty_o,
  input  logic        pop_i,
  output logic [2:0]  status_o,
  output logic        enhanced_o,
  output logic [12:0] frame_bytes_o,
  output logic [15:0] sample_rate_o,
  output logic [22:0] bit_rate_o,
  output logic [2:0]  channels_o,
  output logic [13:0] duration_ticks_o
);

  back_state_e     state_q, state_d;
  hdr_item_t       cur_q;
  logic [22:0]     br_q;
  logic [13:0]     dur_q;
  logic [DivW-1:0] prod_q;
  logic            div_start, div_done;
  logic [DivW-1:0] div_a, div_b, div_quot;
  logic            out_valid_q, out_free, load_out;
  hdr_item_t       out_q;
  logic [22:0]     out_br_q;
  logic [13:0]     out_dur_q;

  assign out_free = !out_valid_q || pop_i;

  ac3eac_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_a),
    .divisor_i  (div_b),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  // Sequencer over bit rate division, duration product and duration division.
  always_comb begin
    state_d   = state_q;
    q_pop_o   = 1'b0;
    div_start = 1'b0;
    div_a     = item_i.rate_num;
    div_b     = {{(DivW-8){1'b0}}, item_i.rate_den};
    load_out  = 1'b0;
    unique case (state_q)
      B_IDLE: begin
        if (!q_empty_i) begin
          q_pop_o   = 1'b1;
          div_start = 1'b1;
          state_d   = B_DIV1;
        end
      end
      B_DIV1: if (div_done) state_d = B_MUL;
      B_MUL: begin
        div_start = 1'b1;
        div_a     = prod_q;
        div_b     = {{(DivW-23){1'b0}}, br_q};
        state_d   = B_DIV2;
      end
      B_DIV2: if (div_done) state_d = B_OUT;
      B_OUT: begin
        if (out_free) begin
          load_out = 1'b1;
          state_d  = B_IDLE;
        end
      end
      default: state_d = B_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= B_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Working registers of the request in progress.
  always_ff @(posedge clk_i) begin
    if (q_pop_o) cur_q <= item_i;
    if (state_q == B_DIV1 && div_done) begin
      br_q   <= div_quot[22:0];
      prod_q <= DivW'(cur_q.frame_bytes) * DivW'(TicksBits);
    end
    if (state_q == B_DIV2 && div_done) begin
      dur_q <= (br_q == '0) ? '0 : div_quot[13:0];
    end
  end

  // Result register facing the consumer.
  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_q     <= cur_q;
      out_br_q  <= br_q;
      out_dur_q <= dur_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (pop_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign empty_o          = !out_valid_q;
  assign status_o         = out_q.status;
  assign enhanced_o       = out_q.enhanced;
  assign frame_bytes_o    = out_q.frame_bytes;
  assign sample_rate_o    = out_q.sample_rate;
  assign bit_rate_o       = out_br_q;
  assign channels_o       = out_q.channels;
  assign duration_ticks_o = out_dur_q;

endmodule

>>> rtl/core/ac3_eac3_header_decoder.sv
// Top level of the AC-3 / E-AC-3 sync frame header decoder.
// Depends on ac3eac_pkg, ac3eac_front, ac3eac_queue and ac3eac_back.
//
//   Channel  | Handshake     | Payload
//   ---------+---------------+--------------------------------------------------
//   header   | push/full     | header_bits_i
//   result   | pop/empty     | status, enhanced, frame_bytes, sample_rate,
//            |               | bit_rate, channels, duration_ticks (_o)
//
// Each header passes the back end in order: pop from the queue, a pass of the shared
// divider for the bit rate and its completion, the duration product, a second pass
// for the duration and its completion, then the result load.
// Headers are accepted every cycle until the two-entry request queue fills.
// Reset clears the queue, the sequencer and the result valid flag.
// A waiting result stalls only the back end; the front keeps filling the queue.
module ac3_eac3_header_decoder import ac3eac_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push,
  output logic            full,
  input  logic [HdrW-1:0] header_bits_i,
  output logic            empty,
  input  logic            pop,
  output logic [2:0]      status_o,
  output logic            enhanced_o,
  output logic [12:0]     frame_bytes_o,
  output logic [15:0]     sample_rate_o,
  output logic [22:0]     bit_rate_o,
  output logic [2:0]      channels_o,
  output logic [13:0]     duration_ticks_o
);

  hdr_item_t front_item, q_item;
  logic      q_empty, q_pop;

  ac3eac_front u_front (
    .header_bits_i (header_bits_i),
    .item_o        (front_item)
  );

  ac3eac_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (front_item),
    .full_o  (full),
    .pop_i   (q_pop),
    .empty_o (q_empty),
    .item_o  (q_item)
  );

  ac3eac_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .q_empty_i        (q_empty),
    .item_i           (q_item),
    .q_pop_o          (q_pop),
    .empty_o          (empty),
    .pop_i            (pop),
    .status_o         (status_o),
    .enhanced_o       (enhanced_o),
    .frame_bytes_o    (frame_bytes_o),
    .sample_rate_o    (sample_rate_o),
    .bit_rate_o       (bit_rate_o),
    .channels_o       (channels_o),
    .duration_ticks_o (duration_ticks_o)
  );

endmodule
